@@ src/utf8_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_pkg
// Shared constants for the UTF-8 code point stream decoder.
// ----------------------------------------------------------------------------
package utf8_pkg;

	localparam longint unsigned MAX_STRING_BYTES_DEF = 64'd65536;

	localparam int CP_W   = 21;
	localparam int POS_W  = 16;
	localparam int ADV_W  = 32;
	localparam int EMA_W  = 16;
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 2;

	// lead byte classification
	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD2_MASK  = 8'hE0;
	localparam logic [7:0] LEAD2_CODE  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK  = 8'hF0;
	localparam logic [7:0] LEAD3_CODE  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK  = 8'hF8;
	localparam logic [7:0] LEAD4_CODE  = 8'hF0;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_CODE   = 8'h80;

	// payload masks
	localparam logic [7:0] LEAD2_BITS = 8'h1F;
	localparam logic [7:0] LEAD3_BITS = 8'h0F;
	localparam logic [7:0] LEAD4_BITS = 8'h07;
	localparam logic [7:0] CONT_BITS  = 8'h3F;

	localparam logic [CP_W-1:0]  REPLACEMENT = 21'h00FFFD;
	localparam logic [ADV_W-1:0] ADV_MAX     = 32'hFFFF_FFFF;

endpackage

@@ src/utf8_codepoint_stream_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_codepoint_stream_decoder
// Decodes a UTF-8 byte stream into code points with start offset and a
// saturating running advance total.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+------------------------------
//  in       | input     | in_valid / in_ready  | text_byte, final_byte
//  out      | output    | out_valid / out_ready| glyph_valid, code_point,
//           |           |                      | cluster_offset, advance_total,
//           |           |                      | run_end
//  cfg      | input     | cfg_valid / cfg_ready| glyph_advance
//
// One byte per cycle sustained unless the output stalls. A byte is held in the
// input register, is decoded against the string state, and its word (if any)
// is loaded into the output register, which raises out_valid.
// The input register keeps taking bytes while the output word waits, and
// stalls only when a byte that produces a word finds the output register full.
// Reset clears all string state and the advance register; cfg_ready is always high.
// ----------------------------------------------------------------------------
module utf8_codepoint_stream_decoder #(
	parameter longint unsigned MAX_STRING_BYTES = utf8_pkg::MAX_STRING_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [utf8_pkg::BYTE_W-1:0] text_byte,
	input  logic                        final_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        glyph_valid,
	output logic [utf8_pkg::CP_W-1:0]   code_point,
	output logic [utf8_pkg::POS_W-1:0]  cluster_offset,
	output logic [utf8_pkg::ADV_W-1:0]  advance_total,
	output logic                        run_end,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [utf8_pkg::EMA_W-1:0]  glyph_advance
);

	localparam int CP_W  = utf8_pkg::CP_W;
	localparam int POS_W = utf8_pkg::POS_W;
	localparam int ADV_W = utf8_pkg::ADV_W;
	localparam int EMA_W = utf8_pkg::EMA_W;
	localparam int CNT_W = utf8_pkg::CNT_W;

	localparam longint unsigned LIM_RAW = (MAX_STRING_BYTES == 0) ? 0 : MAX_STRING_BYTES - 1;
	localparam logic [POS_W-1:0] POS_LIMIT =
		(LIM_RAW > 64'hFFFF) ? {POS_W{1'b1}} : LIM_RAW[POS_W-1:0];

	// input register
	logic       in_vld_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;

	// string state
	logic [CP_W-1:0]  partial_q;
	logic [CNT_W-1:0] expected_q;
	logic [POS_W-1:0] seq_start_q;
	logic [POS_W-1:0] byte_pos_q;
	logic             stopped_q;
	logic [ADV_W-1:0] run_adv_q;
	logic [EMA_W-1:0] em_adv_q;

	// next state / decode
	logic [CP_W-1:0]  partial_d;
	logic [CNT_W-1:0] expected_d;
	logic [POS_W-1:0] seq_start_d;
	logic             stopped_d;
	logic [ADV_W-1:0] run_adv_d;
	logic             have;
	logic             glyph;
	logic [CP_W-1:0]  cp;
	logic [POS_W-1:0] cl;
	logic [CP_W-1:0]  shifted;
	logic [ADV_W:0]   adv_sum;
	logic             emit;
	logic             step;

	always_comb begin
		partial_d   = partial_q;
		expected_d  = expected_q;
		seq_start_d = seq_start_q;
		stopped_d   = stopped_q;
		run_adv_d   = run_adv_q;
		have        = 1'b0;
		glyph       = 1'b0;
		cp          = '0;
		cl          = '0;
		shifted     = {partial_q[CP_W-7:0], byte_s1[5:0] & utf8_pkg::CONT_BITS[5:0]};
		adv_sum     = {1'b0, run_adv_q} + {{(ADV_W+1-EMA_W){1'b0}}, em_adv_q};

		if (!stopped_q) begin
			if (expected_q == '0) begin
				if (byte_s1 < utf8_pkg::ASCII_LIMIT) begin
					cp   = {{(CP_W-8){1'b0}}, byte_s1};
					cl   = byte_pos_q;
					have = 1'b1;
				end else if ((byte_s1 & utf8_pkg::LEAD2_MASK) == utf8_pkg::LEAD2_CODE) begin
					partial_d   = {{(CP_W-8){1'b0}}, byte_s1 & utf8_pkg::LEAD2_BITS};
					expected_d  = CNT_W'(1);
					seq_start_d = byte_pos_q;
				end else if ((byte_s1 & utf8_pkg::LEAD3_MASK) == utf8_pkg::LEAD3_CODE) begin
					partial_d   = {{(CP_W-8){1'b0}}, byte_s1 & utf8_pkg::LEAD3_BITS};
					expected_d  = CNT_W'(2);
					seq_start_d = byte_pos_q;
				end else if ((byte_s1 & utf8_pkg::LEAD4_MASK) == utf8_pkg::LEAD4_CODE) begin
					partial_d   = {{(CP_W-8){1'b0}}, byte_s1 & utf8_pkg::LEAD4_BITS};
					expected_d  = CNT_W'(3);
					seq_start_d = byte_pos_q;
				end else begin
					cp   = utf8_pkg::REPLACEMENT;
					cl   = byte_pos_q;
					have = 1'b1;
				end
			end else if ((byte_s1 & utf8_pkg::CONT_MASK) != utf8_pkg::CONT_CODE) begin
				cp         = utf8_pkg::REPLACEMENT;
				cl         = seq_start_q;
				have       = 1'b1;
				expected_d = '0;
				partial_d  = '0;
			end else begin
				partial_d  = shifted;
				expected_d = expected_q - CNT_W'(1);
				if (expected_q == CNT_W'(1)) begin
					cp        = shifted;
					cl        = seq_start_q;
					have      = 1'b1;
					partial_d = '0;
				end
			end
			// string ends mid-sequence: flush what was gathered
			if (!have && fin_s1 && expected_d != '0) begin
				cp         = partial_d;
				cl         = seq_start_d;
				have       = 1'b1;
				expected_d = '0;
				partial_d  = '0;
			end
			if (have) begin
				if (cp == '0) begin
					stopped_d = 1'b1;
				end else begin
					glyph     = 1'b1;
					run_adv_d = adv_sum[ADV_W] ? utf8_pkg::ADV_MAX : adv_sum[ADV_W-1:0];
				end
			end
		end
	end

	assign emit      = glyph || fin_s1;
	assign step      = in_vld_s1 && (!emit || !out_valid || out_ready);
	assign in_ready  = !in_vld_s1 || step;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1   <= 1'b0;
			partial_q   <= '0;
			expected_q  <= '0;
			seq_start_q <= '0;
			byte_pos_q  <= '0;
			stopped_q   <= 1'b0;
			run_adv_q   <= '0;
			em_adv_q    <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (in_ready) begin
				in_vld_s1 <= in_valid;
			end
			if (cfg_valid) begin
				em_adv_q <= glyph_advance;
			end
			// a new word loads, or the held one stays until taken
			out_valid <= (step && emit) || (out_valid && !out_ready);
			if (step) begin
				if (fin_s1) begin
					partial_q   <= '0;
					expected_q  <= '0;
					seq_start_q <= '0;
					byte_pos_q  <= '0;
					stopped_q   <= 1'b0;
					run_adv_q   <= '0;
				end else begin
					partial_q   <= partial_d;
					expected_q  <= expected_d;
					seq_start_q <= seq_start_d;
					stopped_q   <= stopped_d;
					run_adv_q   <= run_adv_d;
					if (byte_pos_q < POS_LIMIT) begin
						byte_pos_q <= byte_pos_q + POS_W'(1);
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
			fin_s1  <= final_byte;
		end
		if (step && emit) begin
			glyph_valid    <= glyph;
			code_point     <= glyph ? cp : '0;
			cluster_offset <= glyph ? cl : '0;
			advance_total  <= run_adv_d;
			run_end        <= fin_s1;
		end
	end

endmodule

@@ dv/utf8_codepoint_stream_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_codepoint_stream_decoder_tb
// Self-checking bench for the UTF-8 decoder. A table of hand-picked bytes is
// followed by random strings under several advance settings and one longer
// string of mostly plain characters. Every accepted byte is run through an in-bench
// decoder, and each output word is compared field by field with the oldest
// expected word.
// ----------------------------------------------------------------------------
module utf8_codepoint_stream_decoder_tb;

	localparam int CP_W   = utf8_pkg::CP_W;
	localparam int POS_W  = utf8_pkg::POS_W;
	localparam int ADV_W  = utf8_pkg::ADV_W;
	localparam int EMA_W  = utf8_pkg::EMA_W;
	localparam int BYTE_W = utf8_pkg::BYTE_W;
	localparam int CNT_W  = utf8_pkg::CNT_W;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_BYTES  = 100;
	localparam int LONG_BYTES   = 40;
	localparam int MAX_REPORTS  = 40;
	localparam int IDLE_PCT     = 23;
	localparam logic [POS_W-1:0] POS_CAP =
		(utf8_pkg::MAX_STRING_BYTES_DEF - 64'd1 > 64'hFFFF) ? 16'hFFFF
			: POS_W'(utf8_pkg::MAX_STRING_BYTES_DEF - 64'd1);

	localparam bit KNOWN = 1'b1;
	localparam bit PRED  = 1'b0;

	typedef struct packed {
		logic             glyph;
		logic [CP_W-1:0]  point;
		logic [POS_W-1:0] offset;
		logic [ADV_W-1:0] total;
		logic             last;
	} word_t;

	typedef struct packed {
		logic [7:0] b;
		logic       fin;
		logic       known;
		word_t      w;
	} row_t;

	localparam word_t NO_WORD = '0;

	// typed rows are taken with the advance at its reset value of zero
	localparam int PLAN_LEN = 25;
	localparam row_t PLAN [PLAN_LEN] = '{
		'{8'h41, 1'b0, KNOWN, '{1'b1, 21'h41,   16'd0,  32'd0, 1'b0}},
		'{8'h7F, 1'b0, KNOWN, '{1'b1, 21'h7F,   16'd1,  32'd0, 1'b0}},
		'{8'h80, 1'b0, KNOWN, '{1'b1, 21'hFFFD, 16'd2,  32'd0, 1'b0}},
		'{8'hC3, 1'b0, PRED,  NO_WORD},
		'{8'hA9, 1'b0, PRED,  NO_WORD},
		'{8'hE2, 1'b0, PRED,  NO_WORD},
		'{8'h82, 1'b0, PRED,  NO_WORD},
		'{8'hAC, 1'b0, PRED,  NO_WORD},
		'{8'hF7, 1'b0, PRED,  NO_WORD},
		'{8'hBF, 1'b0, PRED,  NO_WORD},
		'{8'hBF, 1'b0, PRED,  NO_WORD},
		'{8'hBF, 1'b0, PRED,  NO_WORD},
		'{8'hF8, 1'b0, KNOWN, '{1'b1, 21'hFFFD, 16'd12, 32'd0, 1'b0}},
		'{8'hFF, 1'b0, KNOWN, '{1'b1, 21'hFFFD, 16'd13, 32'd0, 1'b0}},
		'{8'hE4, 1'b0, PRED,  NO_WORD},
		'{8'h41, 1'b0, PRED,  NO_WORD},
		'{8'hC2, 1'b1, KNOWN, '{1'b1, 21'h2,    16'd16, 32'd0, 1'b1}},
		'{8'hE0, 1'b0, PRED,  NO_WORD},
		'{8'h80, 1'b1, KNOWN, '{1'b0, 21'h0,    16'd0,  32'd0, 1'b1}},
		'{8'h00, 1'b1, KNOWN, '{1'b0, 21'h0,    16'd0,  32'd0, 1'b1}},
		'{8'hC0, 1'b0, PRED,  NO_WORD},
		'{8'h80, 1'b0, PRED,  NO_WORD},
		'{8'h41, 1'b0, PRED,  NO_WORD},
		'{8'hFF, 1'b1, KNOWN, '{1'b0, 21'h0,    16'd0,  32'd0, 1'b1}},
		'{8'h41, 1'b1, KNOWN, '{1'b1, 21'h41,   16'd0,  32'd0, 1'b1}}
	};

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_ready;
	logic [BYTE_W-1:0]  text_byte     = '0;
	logic               final_byte    = 1'b0;
	logic               out_valid;
	logic               out_ready     = 1'b0;
	logic               glyph_valid;
	logic [CP_W-1:0]    code_point;
	logic [POS_W-1:0]   cluster_offset;
	logic [ADV_W-1:0]   advance_total;
	logic               run_end;
	logic               cfg_valid     = 1'b0;
	logic               cfg_ready;
	logic [EMA_W-1:0]   glyph_advance = '0;

	// decoder state mirrored by the bench
	logic [CP_W-1:0]    pend_code  = '0;
	logic [CNT_W-1:0]   conts_left = '0;
	logic [POS_W-1:0]   seq_origin = '0;
	logic [POS_W-1:0]   byte_idx   = '0;
	bit                 halted     = 1'b0;
	logic [ADV_W-1:0]   adv_sum    = '0;
	logic [EMA_W-1:0]   adv_step   = '0;

	word_t              word_q[$];
	logic [7:0]         str_q[$];
	bit                 calm         = 1'b0;
	int                 errors       = 0;
	int                 sent_bytes   = 0;
	int                 quiet_cycles = 0;

	utf8_codepoint_stream_decoder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.text_byte      (text_byte),
		.final_byte     (final_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.glyph_valid    (glyph_valid),
		.code_point     (code_point),
		.cluster_offset (cluster_offset),
		.advance_total  (advance_total),
		.run_end        (run_end),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.glyph_advance  (glyph_advance)
	);

	always #10 clk = ~clk;

	task automatic flag_mismatch(input string what, input logic [31:0] seen,
			input logic [31:0] want);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t mismatch %s: got %h want %h", $realtime, what, seen, want);
	endtask

	// one step of the decoder: updates the mirrored state, returns the word if any
	task automatic decode_byte(input logic [7:0] b, input logic fin, output bit got,
			output word_t w);
		logic [CP_W-1:0]  cp;
		logic [POS_W-1:0] cl;
		bit               have;
		bit               glyph;
		logic [ADV_W:0]   sum;
		cp = '0;
		cl = '0;
		have = 1'b0;
		glyph = 1'b0;
		if (!halted) begin
			if (conts_left == 0) begin
				if (b < utf8_pkg::ASCII_LIMIT) begin
					cp = CP_W'(b);
					cl = byte_idx;
					have = 1'b1;
				end else if ((b & utf8_pkg::LEAD2_MASK) == utf8_pkg::LEAD2_CODE) begin
					pend_code = CP_W'(b & utf8_pkg::LEAD2_BITS);
					conts_left = 2'd1;
					seq_origin = byte_idx;
				end else if ((b & utf8_pkg::LEAD3_MASK) == utf8_pkg::LEAD3_CODE) begin
					pend_code = CP_W'(b & utf8_pkg::LEAD3_BITS);
					conts_left = 2'd2;
					seq_origin = byte_idx;
				end else if ((b & utf8_pkg::LEAD4_MASK) == utf8_pkg::LEAD4_CODE) begin
					pend_code = CP_W'(b & utf8_pkg::LEAD4_BITS);
					conts_left = 2'd3;
					seq_origin = byte_idx;
				end else begin
					cp = utf8_pkg::REPLACEMENT;
					cl = byte_idx;
					have = 1'b1;
				end
			end else if ((b & utf8_pkg::CONT_MASK) != utf8_pkg::CONT_CODE) begin
				// broken sequence: replacement at its start, offending byte eaten
				cp = utf8_pkg::REPLACEMENT;
				cl = seq_origin;
				have = 1'b1;
				conts_left = '0;
				pend_code = '0;
			end else begin
				pend_code = {pend_code[CP_W-7:0], b[5:0]};
				conts_left = conts_left - 2'd1;
				if (conts_left == 0) begin
					cp = pend_code;
					cl = seq_origin;
					have = 1'b1;
					pend_code = '0;
				end
			end
			// string ends mid-sequence: flush what we have
			if (!have && fin && conts_left != 0) begin
				cp = pend_code;
				cl = seq_origin;
				have = 1'b1;
				conts_left = '0;
				pend_code = '0;
			end
			if (have) begin
				if (cp == 0) begin
					halted = 1'b1;
				end else begin
					glyph = 1'b1;
					sum = {1'b0, adv_sum} + (ADV_W + 1)'(adv_step);
					adv_sum = sum[ADV_W] ? utf8_pkg::ADV_MAX : sum[ADV_W-1:0];
				end
			end
		end
		if (byte_idx < POS_CAP)
			byte_idx = byte_idx + 1'b1;
		got = glyph || fin;
		w.glyph = glyph;
		w.point = glyph ? cp : '0;
		w.offset = glyph ? cl : '0;
		w.total = adv_sum;
		w.last = fin;
		if (fin) begin
			pend_code = '0;
			conts_left = '0;
			seq_origin = '0;
			byte_idx = '0;
			halted = 1'b0;
			adv_sum = '0;
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic fin, input bit known,
			input word_t typed);
		bit    got;
		word_t w;
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		text_byte <= b;
		final_byte <= fin;
		do @(posedge clk); while (!in_ready);
		decode_byte(b, fin, got, w);
		if (known)
			word_q = {word_q, typed};
		else if (got)
			word_q = {word_q, w};
		sent_bytes++;
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (word_q.size() != 0);
	endtask

	task automatic settle();
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_advance(input logic [EMA_W-1:0] v);
		cfg_valid <= 1'b1;
		glyph_advance <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		adv_step = v;
	endtask

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic logic [7:0] lead_byte(input int len);
		case (len)
			2:       return 8'hC0 | 8'($urandom_range(0, 31));
			3:       return 8'hE0 | 8'($urandom_range(0, 15));
			default: return 8'hF0 | 8'($urandom_range(0, 7));
		endcase
	endfunction

	// mostly well-formed sequences with random payload, plus noise and broken ones
	task automatic build_string();
		int n;
		int r;
		int len;
		int k;
		str_q.delete();
		n = $urandom_range(1, 10);
		repeat (n) begin
			r = $urandom_range(0, 99);
			len = $urandom_range(1, 4);
			if (r < 70) begin
				if (len == 1) begin
					str_q = {str_q, 8'($urandom_range(0, 127))};
				end else begin
					str_q = {str_q, lead_byte(len)};
					repeat (len - 1) str_q = {str_q, cont_byte()};
				end
			end else if (r < 85) begin
				str_q = {str_q, 8'($urandom_range(0, 255))};
			end else begin
				len = $urandom_range(2, 4);
				str_q = {str_q, lead_byte(len)};
				k = $urandom_range(0, len - 2);
				repeat (k) str_q = {str_q, cont_byte()};
				if ($urandom_range(0, 3) != 0)
					str_q = {str_q, ($urandom_range(0, 1) ? 8'($urandom_range(0, 127))
						: 8'($urandom_range(192, 255)))};
			end
		end
	endtask

	task automatic random_phase(input logic [EMA_W-1:0] step, input bit quiet,
			input bit hold_mid);
		int start;
		bit held;
		write_advance(step);
		calm = quiet;
		start = sent_bytes;
		held = 1'b0;
		while (sent_bytes - start < PHASE_BYTES) begin
			build_string();
			foreach (str_q[i])
				push_byte(str_q[i], i == str_q.size() - 1, PRED, NO_WORD);
			if (hold_mid && !held && sent_bytes - start > PHASE_BYTES / 2) begin
				wait_results();
				held = 1'b1;
			end
		end
		calm = 1'b0;
		settle();
	endtask

	always @(posedge clk)
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

	always @(posedge clk) begin : word_check
		word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (word_q.size() == 0) begin
				flag_mismatch("unexpected word, code_point", 32'(code_point), '0);
			end else begin
				want = word_q.pop_front();
				if (glyph_valid !== want.glyph)
					flag_mismatch("glyph_valid", 32'(glyph_valid), 32'(want.glyph));
				if (code_point !== want.point)
					flag_mismatch("code_point", 32'(code_point), 32'(want.point));
				if (cluster_offset !== want.offset)
					flag_mismatch("cluster_offset", 32'(cluster_offset), 32'(want.offset));
				if (advance_total !== want.total)
					flag_mismatch("advance_total", advance_total, want.total);
				if (run_end !== want.last)
					flag_mismatch("run_end", 32'(run_end), 32'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_LEN; i++)
			push_byte(PLAN[i].b, PLAN[i].fin, PLAN[i].known, PLAN[i].w);
		settle();

		random_phase(16'hFFFF, 1'b1, 1'b0);
		random_phase(16'h0000, 1'b0, 1'b0);
		random_phase(16'h0001, 1'b0, 1'b1);
		random_phase(EMA_W'($urandom_range(0, 65535)), 1'b0, 1'b0);

		// one longer string, ending on a truncated four-byte lead
		write_advance(16'hFFFF);
		for (int i = 0; i < LONG_BYTES; i++)
			push_byte(8'($urandom_range(1, 127)), 1'b0, PRED, NO_WORD);
		push_byte(8'hC3, 1'b0, PRED, NO_WORD);
		push_byte(8'hA9, 1'b0, PRED, NO_WORD);
		push_byte(8'hF1, 1'b1, PRED, NO_WORD);
		settle();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
src/utf8_pkg.sv
src/utf8_codepoint_stream_decoder.sv
dv/utf8_codepoint_stream_decoder_tb.sv
